// File: rtl/assert_macros.svh
// Assertion macros included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that must hold on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication that must hold outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/e2q_pkg.sv
//------------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and tables for the Euler angle to quaternion core.
//------------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;
    localparam int ANGLE_BITS_DEF     = 16;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int TRIG_STAGES_DEF    = 16;
    localparam int MAX_STAGES         = 32;
    localparam int TW                 = 34;
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic signed [TW-1:0] K_Q30 = 34'sd652032874;

    typedef logic signed [TW-1:0] trig_t;

    typedef struct packed {
        trig_t c;
        trig_t s;
    } sincos_t;

    function automatic trig_t atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;   2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;   4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;   8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF;  20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF;  23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F;  26: v = 32'h0000000F;
            27: v = 32'h00000008; 28: v = 32'h00000004;  29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return trig_t'({2'b00, v});
    endfunction

    // Rounded Q2.30 product, floor((a*b + 2^29) / 2^30).
    function automatic trig_t mulq(input trig_t a, input trig_t b);
        logic signed [2*TW-1:0] p;
        p = (a * b) + (68'sd1 <<< 29);
        return trig_t'(p >>> 30);
    endfunction
endpackage
`default_nettype wire

// File: rtl/euler_to_quaternion_core.sv
//------------------------------------------------------------------------------
// euler_to_quaternion_core
// Converts pitch, yaw and roll binary angles into a rotation quaternion.
//------------------------------------------------------------------------------
// The input channel takes one item per cycle when not stalled, each holding
// pitch_angle, yaw_angle and roll_angle as signed binary angles, where the
// full code range spans minus pi to pi. The output channel gives quat_w,
// quat_x, quat_y and quat_z in signed Q2.(COMPONENT_BITS-2).
// Three CORDIC pipelines run side by side; after them the combine stages
// form pair products, triple products, sums and the rounded output.
// The throughput is one item every cycle, set by the fully pipelined CORDICs,
// while the receiver does not stall a waiting result.
// The whole pipe moves as one: when the receiver stalls while a result is
// waiting, every stage holds, so no item is lost or repeated. The input is
// stalled only while the output is stalled and holds a valid result.
// Reset clears only the valid bits; the data registers need no reset.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module euler_to_quaternion_core #(
    parameter int ANGLE_BITS     = e2q_pkg::ANGLE_BITS_DEF,
    parameter int COMPONENT_BITS = e2q_pkg::COMPONENT_BITS_DEF,
    parameter int TRIG_STAGES    = e2q_pkg::TRIG_STAGES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [ANGLE_BITS-1:0]     pitch_angle,
    input  wire logic signed [ANGLE_BITS-1:0]     yaw_angle,
    input  wire logic signed [ANGLE_BITS-1:0]     roll_angle,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [COMPONENT_BITS-1:0]      quat_w,
    output logic signed [COMPONENT_BITS-1:0]      quat_x,
    output logic signed [COMPONENT_BITS-1:0]      quat_y,
    output logic signed [COMPONENT_BITS-1:0]      quat_z
);
    import e2q_pkg::*;

    localparam int NS    = (TRIG_STAGES < MAX_STAGES) ? TRIG_STAGES : MAX_STAGES;
    localparam int DEPTH = NS + 5;

    logic    en;
    logic    [DEPTH-1:0] valid_reg;
    sincos_t sc_yaw, sc_pitch, sc_roll;

    // The pipe advances unless a finished result is held by the receiver.
    assign en        = !(out_stall && valid_reg[DEPTH-1]);
    assign in_stall  = !en;
    assign out_valid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .clk(clk), .en(en), .angle(yaw_angle), .sc(sc_yaw));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .clk(clk), .en(en), .angle(pitch_angle), .sc(sc_pitch));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_roll (
        .clk(clk), .en(en), .angle(roll_angle), .sc(sc_roll));

    e2q_combine #(.COMPONENT_BITS(COMPONENT_BITS)) u_combine (
        .clk(clk), .en(en), .t1(sc_yaw), .t2(sc_pitch), .t3(sc_roll),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z));

    // A held result keeps its valid and the whole pipe freezes.
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_hold_pipe, clk, rst_n, out_valid && out_stall, $stable(valid_reg))
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
endmodule
`default_nettype wire

// File: rtl/e2q_cordic.sv
//------------------------------------------------------------------------------
// e2q_cordic
// Half-angle scaling and a pipelined rotation-mode CORDIC, one stage per
// register, giving cosine and sine in Q2.30.
//------------------------------------------------------------------------------
`default_nettype none
module e2q_cordic #(
    parameter int ANGLE_BITS  = e2q_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [ANGLE_BITS-1:0] angle,
    output e2q_pkg::sincos_t                  sc
);
    import e2q_pkg::*;

    localparam int NS = (TRIG_STAGES < MAX_STAGES) ? TRIG_STAGES : MAX_STAGES;

    // Half angle: a * PI_Q30, an ANGLE_BITS x 33 multiply, registered.
    logic signed [ANGLE_BITS+33:0] prod;
    trig_t theta_reg;
    assign prod = angle * $signed({2'b00, PI_Q30});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= trig_t'(prod >>> ANGLE_BITS);
        end
    end

    // Stage i leaves its rotated vector and residual angle in entry i.
    trig_t x_reg [NS];
    trig_t y_reg [NS];
    trig_t z_reg [NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        trig_t xs, ys, zs;

        if (i == 0)
        begin : g_first
            assign xs = K_Q30;
            assign ys = '0;
            assign zs = theta_reg;
        end
        else
        begin : g_next
            assign xs = x_reg[i-1];
            assign ys = y_reg[i-1];
            assign zs = z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zs[TW-1])
                begin
                    x_reg[i] <= xs - (ys >>> i);
                    y_reg[i] <= ys + (xs >>> i);
                    z_reg[i] <= zs - atan_q30(i);
                end
                else
                begin
                    x_reg[i] <= xs + (ys >>> i);
                    y_reg[i] <= ys - (xs >>> i);
                    z_reg[i] <= zs + atan_q30(i);
                end
            end
        end
    end

    assign sc.c = x_reg[NS-1];
    assign sc.s = y_reg[NS-1];
endmodule
`default_nettype wire

// File: rtl/e2q_combine.sv
//------------------------------------------------------------------------------
// e2q_combine
// Forms pair and triple products, sums them and rounds to the output format.
//------------------------------------------------------------------------------
`default_nettype none
module e2q_combine #(
    parameter int COMPONENT_BITS = e2q_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  e2q_pkg::sincos_t                      t1,
    input  e2q_pkg::sincos_t                      t2,
    input  e2q_pkg::sincos_t                      t3,
    output logic signed [COMPONENT_BITS-1:0]      quat_w,
    output logic signed [COMPONENT_BITS-1:0]      quat_x,
    output logic signed [COMPONENT_BITS-1:0]      quat_y,
    output logic signed [COMPONENT_BITS-1:0]      quat_z
);
    import e2q_pkg::*;

    localparam int FRAC = COMPONENT_BITS - 2;
    localparam int SH   = 30 - FRAC;

    // Stage A: pair products of yaw and pitch, roll terms delayed.
    trig_t cc_reg, ss_reg, sc_reg, cs_reg, c3_reg, s3_reg;
    // Stage B: triple products.
    trig_t p_reg [8];
    // Stage C: sums.
    trig_t w_reg, x_reg, y_reg, z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg <= mulq(t1.c, t2.c);
            ss_reg <= mulq(t1.s, t2.s);
            sc_reg <= mulq(t1.s, t2.c);
            cs_reg <= mulq(t1.c, t2.s);
            c3_reg <= t3.c;
            s3_reg <= t3.s;
            p_reg[0] <= mulq(cc_reg, c3_reg);
            p_reg[1] <= mulq(ss_reg, s3_reg);
            p_reg[2] <= mulq(ss_reg, c3_reg);
            p_reg[3] <= mulq(cc_reg, s3_reg);
            p_reg[4] <= mulq(sc_reg, c3_reg);
            p_reg[5] <= mulq(cs_reg, s3_reg);
            p_reg[6] <= mulq(cs_reg, c3_reg);
            p_reg[7] <= mulq(sc_reg, s3_reg);
            w_reg <= p_reg[0] - p_reg[1];
            x_reg <= p_reg[2] + p_reg[3];
            y_reg <= p_reg[4] + p_reg[5];
            z_reg <= p_reg[6] - p_reg[7];
        end
    end

    function automatic logic signed [COMPONENT_BITS-1:0] to_comp(input trig_t v);
        logic signed [TW:0] r;
        logic signed [TW:0] lim;
        lim = (TW+1)'(1) <<< FRAC;
        if (SH > 0)
        begin
            r = ($signed({v[TW-1], v})
                 + $signed((TW+1)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
        end
        else
        begin
            r = (TW+1)'({v[TW-1], v} <<< (SH > 0 ? 0 : -SH));
        end
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r[COMPONENT_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_w <= to_comp(w_reg);
            quat_x <= to_comp(x_reg);
            quat_y <= to_comp(y_reg);
            quat_z <= to_comp(z_reg);
        end
    end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Euler angle to quaternion core.
//------------------------------------------------------------------------------
// Directed orientations (zero, extremes, quarter turns, the -pi wrap code)
// are followed by random ones. A scoreboard predicts each quaternion from the
// accepted angles with its own CORDIC and fixed-point combine, and compares
// every accepted result field by field, in order. Sender and receiver idle
// at random in two of three phases so bubbles and stalls hit every stage.
//------------------------------------------------------------------------------
`default_nettype none

// Quaternion predictor and in-order store of expected results.
class quat_scoreboard;
    typedef struct {
        logic signed [15:0] w, x, y, z;
    } quat_t;

    quat_t pending[$];
    int    errors;

    // Floor shift of a 64-bit value.
    static function longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    static function longint half_angle(logic signed [15:0] a);
        longint p;
        p = longint'(a) * longint'(64'd3373259426);
        return fshr(p, 16);
    endfunction

    static function void sincos(longint theta, output longint c, output longint s);
        longint xv, yv, zv, dx, dy;
        xv = 652032874;
        yv = 0;
        zv = theta;
        for (int i = 0; i < 16; i++)
        begin
            dx = fshr(yv, i);
            dy = fshr(xv, i);
            if (zv >= 0)
            begin
                xv -= dx; yv += dy; zv -= longint'(e2q_pkg::atan_q30(i));
            end
            else
            begin
                xv += dx; yv -= dy; zv += longint'(e2q_pkg::atan_q30(i));
            end
        end
        c = xv;
        s = yv;
    endfunction

    static function longint prod(longint a, longint b);
        return fshr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    static function longint prod3(longint a, longint b, longint c);
        return prod(prod(a, b), c);
    endfunction

    // Round a Q2.30 sum to Q2.14 and clamp to plus or minus one.
    static function logic signed [15:0] to_q14(longint v);
        longint r;
        r = fshr(v + (64'sd1 <<< 15), 16);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function void note_angles(logic signed [15:0] pitch, logic signed [15:0] yaw,
                              logic signed [15:0] roll);
        longint c1, s1, c2, s2, c3, s3;
        quat_t q;
        sincos(half_angle(yaw), c1, s1);
        sincos(half_angle(pitch), c2, s2);
        sincos(half_angle(roll), c3, s3);
        q.w = to_q14(prod3(c1, c2, c3) - prod3(s1, s2, s3));
        q.x = to_q14(prod3(s1, s2, c3) + prod3(c1, c2, s3));
        q.y = to_q14(prod3(s1, c2, c3) + prod3(c1, s2, s3));
        q.z = to_q14(prod3(c1, s2, c3) - prod3(s1, c2, s3));
        pending.push_back(q);
    endfunction

    function void check_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        quat_t q;
        if (pending.size() == 0)
        begin
            $error("unexpected result w=%0d x=%0d y=%0d z=%0d", w, x, y, z);
            errors++;
            return;
        end
        q = pending.pop_front();
        if (w !== q.w)
        begin
            $error("quat_w expected %0d actual %0d", q.w, w);
            errors++;
        end
        if (x !== q.x)
        begin
            $error("quat_x expected %0d actual %0d", q.x, x);
            errors++;
        end
        if (y !== q.y)
        begin
            $error("quat_y expected %0d actual %0d", q.y, y);
            errors++;
        end
        if (z !== q.z)
        begin
            $error("quat_z expected %0d actual %0d", q.z, z);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int LATENCY   = 21;
    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] pitch_angle = '0;
    logic signed [15:0] yaw_angle = '0;
    logic signed [15:0] roll_angle = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

    // Percent chance per cycle that the sender or the receiver holds back.
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    quat_scoreboard board = new();

    always #1 clk = ~clk;

    euler_to_quaternion_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    // Receiver: check at each accepting edge, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_quat(quat_w, quat_x, quat_y, quat_z);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one item, optionally after random idle cycles, and hold it until
    // the block accepts it. Valid stays high across back-to-back items.
    task automatic send_angles(logic signed [15:0] pitch, logic signed [15:0] yaw,
                               logic signed [15:0] roll);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pitch_angle <= pitch;
        yaw_angle   <= yaw;
        roll_angle  <= roll;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_angles(pitch, yaw, roll);
    endtask

    function automatic logic signed [15:0] pick_angle();
        // Mostly uniform, sometimes a landmark such as a quarter turn or the ends.
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(($urandom_range(7) << 13) + $urandom_range(2) - 1);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_phase(int gap, int stall, int count);
        send_gap_pct   = gap;
        recv_stall_pct = stall;
        repeat (count)
            send_angles(pick_angle(), pick_angle(), pick_angle());
    endtask

    initial
    begin
        logic signed [15:0] landmarks[8];
        landmarks = '{16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh4000,
                      16'shC000, 16'sh0001, 16'shFFFF, 16'sh2000};
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pitch, yaw alone on all landmarks, roll on six, then all
        // three together, including the -pi wrap code that drives overshoot.
        for (int i = 0; i < 8; i++)
            send_angles(landmarks[i], 16'sh0000, 16'sh0000);
        for (int i = 0; i < 8; i++)
            send_angles(16'sh0000, landmarks[i], 16'sh0000);
        for (int i = 0; i < 6; i++)
            send_angles(16'sh0000, 16'sh0000, landmarks[i]);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_angles(16'sh5555, 16'shAAAA, 16'sh3C3C);

        random_phase(7, 63, 530);
        random_phase(63, 7, 530);
        random_phase(0, 0, 530);
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire
